>>> hdl/byte_ring_buffer_unit_macros.svh
// ----------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication.
`define BRB_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define BRB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/brb_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Sizes and action codes of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH     = 1024;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int SIZE_W    = 11;
  localparam int CNT_W     = 7;
  localparam int STAT_W    = 10;
  localparam int MAX_BURST = 64;
  localparam int ACT_W     = 2;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SKIP  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);
  localparam logic [CNT_W-1:0]  BURST_CAP  = CNT_W'(MAX_BURST);

endpackage

>>> hdl/byte_ring_buffer_unit.sv
// Sequence: an accepted command passes the execute step and then the status step;
// a write, skip, empty read or unused action then gives its one result, and a
// read of n bytes gives them one byte per cycle from the read step.
// No new command is taken until the execute and status steps and all bytes of a
// read are through, the memory port giving one read per cycle.
// Reset: both positions zero, ring size 1024; the byte storage is not cleared.
// ----------------------------------------------------------------------------
// Byte ring buffer unit
// Circular byte FIFO with one slot kept empty, backed by a synchronous RAM.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_unit_macros.svh"

module byte_ring_buffer_unit
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [7:0]        in_write_data,
  input  logic [CNT_W-1:0]  in_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_ring_size,
  output logic              out_strobe,
  output logic [7:0]        out_read_data,
  output logic              out_data_valid,
  output logic              out_accepted,
  output logic              out_last,
  output logic [STAT_W-1:0] out_bytes_waiting,
  output logic [STAT_W-1:0] out_bytes_free,
  output logic [STAT_W-1:0] out_linear_read_length
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_STAT = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] sz_r;
  logic [PTR_W-1:0]  wp_r, rp_r, rd_addr_r;
  logic [STAT_W-1:0] avail_r;
  logic [ACT_W-1:0]  act_r;
  logic [7:0]        data_r;
  logic [CNT_W-1:0]  cnt_r, n_r, rem_r;
  logic              acc_r;
  logic              out_strobe_r, out_valid_r, out_acc_r, out_last_r;
  logic              out_strobe_nxt;
  logic [STAT_W-1:0] stat_wait_r, stat_free_r, stat_lin_r;
  logic [7:0]        mem_q_r;
  logic [7:0]        mem [DEPTH];

  logic              cfg_fire, in_fire;
  logic [SIZE_W-1:0] cfg_size_eff;
  logic              is_full, mem_we, mem_re;
  logic [PTR_W-1:0]  wp_inc, rd_inc;
  logic [CNT_W-1:0]  cnt_cap, n_take;
  logic [SIZE_W-1:0] rp_sum, rp_new;
  logic [SIZE_W-1:0] wait_calc, free_calc, lin_calc;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = start && !busy;

  always_comb begin
    if (cfg_ring_size < SIZE_MIN) begin
      cfg_size_eff = SIZE_MIN;
    end else if (cfg_ring_size > SIZE_MAX) begin
      cfg_size_eff = SIZE_MAX;
    end else begin
      cfg_size_eff = cfg_ring_size;
    end
  end

  // Execute step: the fill level is kept in avail_r, so only the move and wrap remain here.
  always_comb begin
    is_full = ({1'b0, avail_r} == sz_r - SIZE_W'(1));
    wp_inc  = ({1'b0, wp_r} + SIZE_W'(1) == sz_r) ? '0 : wp_r + PTR_W'(1);
    rd_inc  = ({1'b0, rd_addr_r} + SIZE_W'(1) == sz_r) ? '0 : rd_addr_r + PTR_W'(1);
    if (act_r == ACT_READ && cnt_r > BURST_CAP) begin
      cnt_cap = BURST_CAP;
    end else begin
      cnt_cap = cnt_r;
    end
    if (STAT_W'(cnt_cap) < avail_r) begin
      n_take = cnt_cap;
    end else begin
      n_take = avail_r[CNT_W-1:0];
    end
    rp_sum = {1'b0, rp_r} + SIZE_W'(n_take);
    rp_new = (rp_sum >= sz_r) ? rp_sum - sz_r : rp_sum;
  end

  // Status step, from the positions left by the whole transaction.
  always_comb begin
    if (wp_r >= rp_r) begin
      wait_calc = SIZE_W'(wp_r - rp_r);
    end else begin
      wait_calc = sz_r - SIZE_W'(rp_r - wp_r);
    end
    free_calc = sz_r - SIZE_W'(1) - wait_calc;
    if (wp_r > rp_r) begin
      lin_calc = SIZE_W'(wp_r - rp_r);
    end else if (rp_r > wp_r) begin
      lin_calc = sz_r - SIZE_W'(rp_r);
    end else begin
      lin_calc = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_STAT;
      S_STAT: begin
        if (act_r == ACT_READ && n_r != '0) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (rem_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_strobe_nxt = ((state_r == S_STAT) && !(act_r == ACT_READ && n_r != '0)) ||
                          (state_r == S_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sz_r         <= SIZE_MAX;
      wp_r         <= '0;
      rp_r         <= '0;
      avail_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_fire) begin
        sz_r    <= cfg_size_eff;
        wp_r    <= '0;
        rp_r    <= '0;
        avail_r <= '0;
      end
      case (state_r)
        S_EXEC: begin
          if (act_r == ACT_WRITE) begin
            if (!is_full) begin
              wp_r <= wp_inc;
            end
          end else if (act_r == ACT_READ || act_r == ACT_SKIP) begin
            rp_r <= rp_new[PTR_W-1:0];
          end
        end
        S_STAT: avail_r <= wait_calc[STAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Transaction and result payload.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_r  <= in_action;
          data_r <= in_write_data;
          cnt_r  <= in_count;
        end
      end
      S_EXEC: begin
        rd_addr_r <= rp_r;
        n_r       <= n_take;
        rem_r     <= n_take;
        if (act_r == ACT_WRITE) begin
          acc_r <= !is_full;
        end else if (act_r == ACT_READ || act_r == ACT_SKIP) begin
          acc_r <= (n_take != '0);
        end else begin
          acc_r <= 1'b0;
        end
      end
      S_STAT: begin
        stat_wait_r <= wait_calc[STAT_W-1:0];
        stat_free_r <= free_calc[STAT_W-1:0];
        stat_lin_r  <= lin_calc[STAT_W-1:0];
        out_valid_r <= 1'b0;
        out_acc_r   <= acc_r;
        out_last_r  <= 1'b1;
      end
      S_READ: begin
        rd_addr_r   <= rd_inc;
        rem_r       <= rem_r - CNT_W'(1);
        out_valid_r <= 1'b1;
        out_acc_r   <= 1'b1;
        out_last_r  <= (rem_r == CNT_W'(1));
      end
      default: ;
    endcase
  end

  // Items run one at a time, so a read never overlaps a write to the same slot.
  assign mem_we = (state_r == S_EXEC) && (act_r == ACT_WRITE) && !is_full;
  assign mem_re = (state_r == S_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= data_r;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_addr_r];
    end
  end

  assign out_strobe             = out_strobe_r;
  assign out_read_data          = out_valid_r ? mem_q_r : 8'd0;
  assign out_data_valid         = out_valid_r;
  assign out_accepted           = out_acc_r;
  assign out_last               = out_last_r;
  assign out_bytes_waiting      = stat_wait_r;
  assign out_bytes_free         = stat_free_r;
  assign out_linear_read_length = stat_lin_r;

  `BRB_ASSERT_NOW(a_fill_bound, 1'b1, {1'b0, avail_r} < sz_r, "fill level reached ring size")
  `BRB_ASSERT_NOW(a_burst_left, state_r == S_READ, rem_r != '0, "read burst with no bytes left")
  `BRB_ASSERT_NEXT(a_last_gap, out_strobe_r && out_last_r, !out_strobe_r,
                   "result directly after the final result of a transaction")
  `BRB_ASSERT_NOW(a_pos_range, 1'b1, ({1'b0, wp_r} < sz_r) && ({1'b0, rp_r} < sz_r),
                  "position outside the ring")

endmodule

>>> tb/sv/brb_checker.sv
// ----------------------------------------------------------------------------
// Byte ring buffer checker
// Watches the command, configuration and result channels of the ring buffer,
// keeps its own copy of the ring (storage, positions and ring size), works
// out the results of each accepted command and compares every result strobe
// against the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module brb_checker
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [7:0]        in_write_data,
  input  logic [CNT_W-1:0]  in_count,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_ring_size,
  input  logic              out_strobe,
  input  logic [7:0]        out_read_data,
  input  logic              out_data_valid,
  input  logic              out_accepted,
  input  logic              out_last,
  input  logic [STAT_W-1:0] out_bytes_waiting,
  input  logic [STAT_W-1:0] out_bytes_free,
  input  logic [STAT_W-1:0] out_linear_read_length,
  output int                mismatch_count,
  output int                results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]        read_data;
    logic              data_valid;
    logic              accepted;
    logic              last;
    logic [STAT_W-1:0] bytes_waiting;
    logic [STAT_W-1:0] bytes_free;
    logic [STAT_W-1:0] linear_len;
  } ring_result_t;

  logic [7:0]        ring_mem [DEPTH];
  int unsigned       wr_pos;
  int unsigned       rd_pos;
  logic [SIZE_W-1:0] size_reg;
  ring_result_t      owed_q [$];

  // Sizes outside the supported range are pinned to the nearest legal one.
  function automatic int unsigned active_slots();
    if (size_reg < SIZE_MIN) return int'(SIZE_MIN);
    if (size_reg > SIZE_MAX) return DEPTH;
    return int'(size_reg);
  endfunction

  function automatic int unsigned fill_level(int unsigned slots);
    if (wr_pos >= rd_pos) return wr_pos - rd_pos;
    return slots - (rd_pos - wr_pos);
  endfunction

  function automatic int unsigned run_length(int unsigned slots);
    if (wr_pos > rd_pos) return wr_pos - rd_pos;
    if (rd_pos > wr_pos) return slots - rd_pos;
    return 0;
  endfunction

  function automatic ring_result_t make_result(logic [7:0] data, logic valid, logic acc,
                                               logic fin, int unsigned slots);
    ring_result_t r;
    int unsigned  w;
    w = fill_level(slots);
    r.read_data     = data;
    r.data_valid    = valid;
    r.accepted      = acc;
    r.last          = fin;
    r.bytes_waiting = STAT_W'(w);
    r.bytes_free    = STAT_W'(slots - 1 - w);
    r.linear_len    = STAT_W'(run_length(slots));
    return r;
  endfunction

  task automatic predict_command(logic [ACT_W-1:0] act, logic [7:0] wdata,
                                 logic [CNT_W-1:0] cnt);
    int unsigned slots;
    int unsigned avail;
    int unsigned n;
    logic [7:0]  taken [MAX_BURST];
    logic        stored;
    slots = active_slots();
    avail = fill_level(slots);
    case (act)
      ACT_WRITE: begin
        stored = (slots - 1 - avail) > 0;
        if (stored) begin
          ring_mem[wr_pos] = wdata;
          wr_pos = (wr_pos + 1 >= slots) ? 0 : wr_pos + 1;
        end
        owed_q.push_back(make_result(8'h00, 1'b0, stored, 1'b1, slots));
      end
      ACT_SKIP: begin
        n = (cnt < avail) ? cnt : avail;
        rd_pos = rd_pos + n;
        if (rd_pos >= slots) rd_pos = rd_pos - slots;
        owed_q.push_back(make_result(8'h00, 1'b0, n > 0, 1'b1, slots));
      end
      ACT_READ: begin
        n = (cnt > MAX_BURST) ? MAX_BURST : cnt;
        if (n > avail) n = avail;
        for (int k = 0; k < n; k++) begin
          taken[k] = ring_mem[rd_pos];
          rd_pos = (rd_pos + 1 >= slots) ? 0 : rd_pos + 1;
        end
        // The status fields of every byte report the ring after the whole read.
        if (n == 0) owed_q.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1, slots));
        for (int k = 0; k < n; k++) begin
          owed_q.push_back(make_result(taken[k], 1'b1, 1'b1, k == n - 1, slots));
        end
      end
      default: begin
        owed_q.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1, slots));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    ring_result_t want;
    if (owed_q.size() == 0) begin
      $error("result strobe with no result outstanding");
      mismatch_count++;
    end else begin
      want = owed_q.pop_front();
      check_field("read_data", want.read_data, out_read_data);
      check_field("data_valid", want.data_valid, out_data_valid);
      check_field("accepted", want.accepted, out_accepted);
      check_field("last", want.last, out_last);
      check_field("bytes_waiting", want.bytes_waiting, out_bytes_waiting);
      check_field("bytes_free", want.bytes_free, out_bytes_free);
      check_field("linear_read_length", want.linear_len, out_linear_read_length);
    end
  endtask

  // Results leave before a command accepted on the same edge can add any.
  always @(posedge clk) begin
    if (!rst_n) begin
      wr_pos = 0;
      rd_pos = 0;
      size_reg = SIZE_MAX;
      mismatch_count = 0;
      owed_q.delete();
    end else begin
      if (out_strobe) check_result();
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_ring_size;
        wr_pos = 0;
        rd_pos = 0;
      end
      if (start && !busy) predict_command(in_action, in_write_data, in_count);
    end
    results_owed <= owed_q.size();
  end

endmodule

>>> tb/sv/tb_byte_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// Byte ring buffer unit testbench
// Drives directed and random write, read and skip commands through the ring
// buffer across several ring sizes and sender idle rates; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_unit
  import brb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_LIMIT  = 5_000;
  localparam int RANDOM_ITEMS = 400;
  localparam int SEGMENTS     = 6;

  // Code 3 is not a defined action; the block must answer it without effect.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ACT_W-1:0]  in_action = '0;
  logic [7:0]        in_write_data = '0;
  logic [CNT_W-1:0]  in_count = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_ring_size = '0;
  logic              out_strobe;
  logic [7:0]        out_read_data;
  logic              out_data_valid;
  logic              out_accepted;
  logic              out_last;
  logic [STAT_W-1:0] out_bytes_waiting;
  logic [STAT_W-1:0] out_bytes_free;
  logic [STAT_W-1:0] out_linear_read_length;
  int                mismatch_count;
  int                results_owed;

  int                gap_pct = 0;
  int                commands_sent = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  byte_ring_buffer_unit i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_action              (in_action),
    .in_write_data          (in_write_data),
    .in_count               (in_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_ring_size          (cfg_ring_size),
    .out_strobe             (out_strobe),
    .out_read_data          (out_read_data),
    .out_data_valid         (out_data_valid),
    .out_accepted           (out_accepted),
    .out_last               (out_last),
    .out_bytes_waiting      (out_bytes_waiting),
    .out_bytes_free         (out_bytes_free),
    .out_linear_read_length (out_linear_read_length)
  );

  brb_checker i_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_action              (in_action),
    .in_write_data          (in_write_data),
    .in_count               (in_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_ring_size          (cfg_ring_size),
    .out_strobe             (out_strobe),
    .out_read_data          (out_read_data),
    .out_data_valid         (out_data_valid),
    .out_accepted           (out_accepted),
    .out_last               (out_last),
    .out_bytes_waiting      (out_bytes_waiting),
    .out_bytes_free         (out_bytes_free),
    .out_linear_read_length (out_linear_read_length),
    .mismatch_count         (mismatch_count),
    .results_owed           (results_owed)
  );

  // Random idle cycles carry junk on the command fields while start is low.
  task automatic issue(logic [ACT_W-1:0] act, logic [7:0] wdata, logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      in_action <= ACT_W'($urandom);
      in_write_data <= 8'($urandom);
      in_count <= CNT_W'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_write_data <= wdata;
    in_count <= cnt;
    do @(posedge clk); while (busy);
    commands_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic set_ring_size(logic [SIZE_W-1:0] value);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_ring_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a run of writes followed by one read, skip or unused action, so that
  // the ring fills, wraps and drains; now and then a single command of random shape.
  task automatic random_burst();
    int unsigned n_writes;
    int unsigned pick;
    logic [CNT_W-1:0] cnt;
    pick = $urandom_range(99);
    if (pick < 10) begin
      issue(ACT_W'($urandom), 8'($urandom), CNT_W'($urandom));
    end else if (pick < 14) begin
      hold_until_drained();
    end else begin
      n_writes = ($urandom_range(9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 10);
      repeat (n_writes) issue(ACT_WRITE, 8'($urandom), CNT_W'($urandom));
      pick = $urandom_range(99);
      if (pick < 5) cnt = '0;
      else if (pick < 20) cnt = CNT_W'($urandom_range(65, 127));
      else if (pick < 35) cnt = CNT_W'($urandom_range(17, 64));
      else cnt = CNT_W'($urandom_range(1, 12));
      pick = $urandom_range(99);
      if (pick < 75) issue(ACT_READ, 8'($urandom), cnt);
      else if (pick < 95) issue(ACT_SKIP, 8'($urandom), cnt);
      else issue(ACT_UNUSED, 8'($urandom), cnt);
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] seg_size [SEGMENTS];
    int                seg_end;

    seg_size = '{11'd5, 11'd1024, 11'd2, 11'd70, 11'd1500, 11'd3};
    seg_size[SEGMENTS-1] = SIZE_W'($urandom_range(3, 300));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-size ring after reset: empty cases, bounds of the fields, capping.
    issue(ACT_READ, 8'h00, 7'd5);
    issue(ACT_SKIP, 8'h00, 7'd3);
    issue(ACT_UNUSED, 8'hFF, 7'd127);
    issue(ACT_WRITE, 8'h00, 7'd0);
    issue(ACT_WRITE, 8'hFF, 7'd127);
    issue(ACT_WRITE, 8'hA5, 7'd64);
    issue(ACT_READ, 8'h00, 7'd0);
    issue(ACT_READ, 8'h00, 7'd127);
    issue(ACT_WRITE, 8'h3C, 7'd1);
    issue(ACT_SKIP, 8'h00, 7'd127);

    // A size of zero behaves as the smallest ring: one byte fills it.
    set_ring_size(11'd0);
    issue(ACT_WRITE, 8'h5A, 7'd0);
    issue(ACT_WRITE, 8'hC3, 7'd0);
    issue(ACT_READ, 8'h00, 7'd1);
    issue(ACT_SKIP, 8'h00, 7'd1);

    set_ring_size(11'd1);
    issue(ACT_WRITE, 8'h81, 7'd0);
    issue(ACT_SKIP, 8'h00, 7'd1);

    // Three slots: fill, drop, wrap the write position, read across the wrap.
    set_ring_size(11'd3);
    issue(ACT_WRITE, 8'h11, 7'd0);
    issue(ACT_WRITE, 8'h22, 7'd0);
    issue(ACT_WRITE, 8'h33, 7'd0);
    issue(ACT_READ, 8'h00, 7'd1);
    issue(ACT_WRITE, 8'h44, 7'd0);
    issue(ACT_READ, 8'h00, 7'd64);

    // An oversize ring clamps to the full storage.
    set_ring_size(11'd2047);
    issue(ACT_WRITE, 8'h7E, 7'd0);
    issue(ACT_READ, 8'h00, 7'd1);
    hold_until_drained();

    // Random part: sender idle rate changes each third, ring size each sixth.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      gap_pct = (seg < 2) ? 36 : (seg < 4) ? 87 : 0;
      set_ring_size(seg_size[seg]);
      seg_end = commands_sent + RANDOM_ITEMS / SEGMENTS;
      while (commands_sent < seg_end) random_burst();
    end

    start <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && results_owed != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (results_owed != 0) $error("%0d results never arrived", results_owed);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("byte_ring_buffer_unit test passed");
    end else begin
      $display("byte_ring_buffer_unit test failed");
    end
    $finish;
  end

  initial begin
    #(CYCLE_LIMIT * CLK_PERIOD);
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("byte_ring_buffer_unit test failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/brb_pkg.sv
hdl/byte_ring_buffer_unit.sv
tb/sv/brb_checker.sv
tb/sv/tb_byte_ring_buffer_unit.sv
